FILE: hw/rtl/balanced_three_factor_split_top_defines.svh
// ----------------------------------------------------------------------------
// Balanced three factor split: assertion macros
// Shorthand for the concurrent checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef BALANCED_THREE_FACTOR_SPLIT_TOP_DEFINES_SVH
`define BALANCED_THREE_FACTOR_SPLIT_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define BTFS_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define BTFS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/btfs_pkg.sv
// ----------------------------------------------------------------------------
// Balanced three factor split: package
// Widths, types and the command and status groups shared by the modules.
// ----------------------------------------------------------------------------
`default_nettype none

package btfs_pkg;

   localparam int COUNT_WIDTH = 16;
   localparam int FIELD_WIDTH = 16;
   localparam int STEP_BITS   = $clog2(COUNT_WIDTH);

   typedef logic [COUNT_WIDTH-1:0]   cnt_type;
   typedef logic [2*COUNT_WIDTH-1:0] square_type;
   typedef logic [FIELD_WIDTH-1:0]   field_type;
   typedef logic [STEP_BITS-1:0]     step_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_A_START,
      ST_A_WAIT,
      ST_B_START,
      ST_B_WAIT,
      ST_FINISH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic div_start;
      logic div_sel_b;
      logic rem_take;
      logic a_next;
      logic b_init;
      logic b_next;
      logic cand_take;
      logic emit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic div_done;
      logic div_exact;
      logic a_stop;
      logic b_stop;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

FILE: hw/rtl/btfs_req_if.sv
// ----------------------------------------------------------------------------
// Balanced three factor split: request channel
// Valid/ready channel carrying one count per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface btfs_req_if;
   logic                valid;
   logic                ready;
   btfs_pkg::field_type count;

   modport source (output valid, output count, input ready);
   modport sink   (input valid, input count, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/btfs_rsp_if.sv
// ----------------------------------------------------------------------------
// Balanced three factor split: response channel
// Valid/ready channel carrying one factor triple per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface btfs_rsp_if;
   logic                valid;
   logic                ready;
   btfs_pkg::field_type factor_large;
   btfs_pkg::field_type factor_middle;
   btfs_pkg::field_type factor_small;

   modport source (output valid, output factor_large, output factor_middle,
                   output factor_small, input ready);
   modport sink   (input valid, input factor_large, input factor_middle,
                   input factor_small, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/btfs_divider.sv
// ----------------------------------------------------------------------------
// Balanced three factor split: divider
// Restoring divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module btfs_divider (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  btfs_pkg::cnt_type dividend,
   input  btfs_pkg::cnt_type divisor,
   output logic              done,
   output btfs_pkg::cnt_type quotient,
   output btfs_pkg::cnt_type remainder
);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   btfs_pkg::step_type  step_ff, step_in;
   btfs_pkg::cnt_type   quo_ff, quo_in;
   btfs_pkg::cnt_type   rem_ff, rem_in;
   btfs_pkg::cnt_type   dvs_ff, dvs_in;

   logic [btfs_pkg::COUNT_WIDTH:0]   shifted;
   logic [btfs_pkg::COUNT_WIDTH+1:0] trial;
   logic                             fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[btfs_pkg::COUNT_WIDTH-1]};
      trial   = {1'b0, shifted} - {2'b00, dvs_ff};
      fits    = ~trial[btfs_pkg::COUNT_WIDTH+1];

      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;

      if (start) begin
         busy_in = 1'b1;
         step_in = btfs_pkg::step_type'(btfs_pkg::COUNT_WIDTH - 1);
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[btfs_pkg::COUNT_WIDTH-2:0], fits};
         rem_in = fits ? trial[btfs_pkg::COUNT_WIDTH-1:0]
                       : shifted[btfs_pkg::COUNT_WIDTH-1:0];
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/btfs_datapath.sv
// ----------------------------------------------------------------------------
// Balanced three factor split: datapath
// Search registers, shared divider, best-triple tracking and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module btfs_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  btfs_pkg::field_type  count,
   input  btfs_pkg::cmd_type    cmd,
   output btfs_pkg::status_type status,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output btfs_pkg::field_type  rsp_large,
   output btfs_pkg::field_type  rsp_middle,
   output btfs_pkg::field_type  rsp_small
);

   btfs_pkg::cnt_type    n_ff, n_in;
   btfs_pkg::cnt_type    a_ff, a_in;
   btfs_pkg::square_type a_sq_ff, a_sq_in;
   btfs_pkg::cnt_type    b_ff, b_in;
   btfs_pkg::cnt_type    rem_ff, rem_in;
   btfs_pkg::cnt_type    gap_ff, gap_in;
   btfs_pkg::cnt_type    best_large_ff, best_large_in;
   btfs_pkg::cnt_type    best_mid_ff, best_mid_in;
   btfs_pkg::cnt_type    best_small_ff, best_small_in;
   logic                 have_ff, have_in;
   logic                 out_valid_ff, out_valid_in;
   btfs_pkg::field_type  out_large_ff, out_large_in;
   btfs_pkg::field_type  out_mid_ff, out_mid_in;
   btfs_pkg::field_type  out_small_ff, out_small_in;

   btfs_pkg::cnt_type    div_dividend;
   btfs_pkg::cnt_type    div_divisor;
   logic                 div_done;
   btfs_pkg::cnt_type    div_quotient;
   btfs_pkg::cnt_type    div_remainder;
   btfs_pkg::cnt_type    cand_gap;
   logic                 cand_better;

   assign div_dividend = cmd.div_sel_b ? rem_ff : n_ff;
   assign div_divisor  = cmd.div_sel_b ? b_ff : a_ff;

   btfs_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   // With a <= b <= c the gap of a candidate is simply c - a.
   assign cand_gap    = div_quotient - a_ff;
   assign cand_better = ~have_ff || (cand_gap < gap_ff);

   always_comb begin
      status.div_done  = div_done;
      status.div_exact = (div_remainder == '0);
      status.a_stop    = (a_sq_ff > btfs_pkg::square_type'(div_quotient));
      status.b_stop    = (div_quotient < b_ff);
      status.out_free  = ~out_valid_ff || rsp_ready;
   end

   always_comb begin
      n_in          = n_ff;
      a_in          = a_ff;
      a_sq_in       = a_sq_ff;
      b_in          = b_ff;
      rem_in        = rem_ff;
      gap_in        = gap_ff;
      best_large_in = best_large_ff;
      best_mid_in   = best_mid_ff;
      best_small_in = best_small_ff;
      have_in       = have_ff;
      out_valid_in  = out_valid_ff;
      out_large_in  = out_large_ff;
      out_mid_in    = out_mid_ff;
      out_small_in  = out_small_ff;

      if (cmd.load) begin
         n_in          = btfs_pkg::cnt_type'(count);
         a_in          = btfs_pkg::cnt_type'(1);
         a_sq_in       = btfs_pkg::square_type'(1);
         have_in       = 1'b0;
         best_large_in = btfs_pkg::cnt_type'(1);
         best_mid_in   = btfs_pkg::cnt_type'(1);
         best_small_in = '0;
      end
      if (cmd.rem_take) begin
         rem_in = div_quotient;
      end
      if (cmd.a_next) begin
         // (a + 1)^2 = a^2 + 2a + 1
         a_in    = a_ff + 1'b1;
         a_sq_in = a_sq_ff + btfs_pkg::square_type'({a_ff, 1'b0})
                   + btfs_pkg::square_type'(1);
      end
      if (cmd.b_init) begin
         b_in = a_ff;
      end
      if (cmd.b_next) begin
         b_in = b_ff + 1'b1;
      end
      if (cmd.cand_take && cand_better) begin
         have_in       = 1'b1;
         gap_in        = cand_gap;
         best_large_in = div_quotient;
         best_mid_in   = b_ff;
         best_small_in = a_ff;
      end

      if (cmd.emit) begin
         out_valid_in = 1'b1;
         out_large_in = btfs_pkg::field_type'(best_large_ff);
         out_mid_in   = btfs_pkg::field_type'(best_mid_ff);
         out_small_in = btfs_pkg::field_type'(best_small_ff);
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         have_ff      <= have_in;
         out_valid_ff <= out_valid_in;
      end
      n_ff          <= n_in;
      a_ff          <= a_in;
      a_sq_ff       <= a_sq_in;
      b_ff          <= b_in;
      rem_ff        <= rem_in;
      gap_ff        <= gap_in;
      best_large_ff <= best_large_in;
      best_mid_ff   <= best_mid_in;
      best_small_ff <= best_small_in;
      out_large_ff  <= out_large_in;
      out_mid_ff    <= out_mid_in;
      out_small_ff  <= out_small_in;
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_large  = out_large_ff;
   assign rsp_middle = out_mid_ff;
   assign rsp_small  = out_small_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/btfs_ctrl.sv
// ----------------------------------------------------------------------------
// Balanced three factor split: controller
// Sequences the outer and inner divisor loops over the shared divider.
// ----------------------------------------------------------------------------
`default_nettype none

module btfs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  btfs_pkg::status_type status,
   output logic                 req_ready,
   output btfs_pkg::cmd_type    cmd
);

   btfs_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= btfs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;

      unique case (state_ff)
         btfs_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = btfs_pkg::ST_A_START;
            end
         end
         btfs_pkg::ST_A_START: begin
            cmd.div_start = 1'b1;
            state_in      = btfs_pkg::ST_A_WAIT;
         end
         btfs_pkg::ST_A_WAIT: begin
            if (status.div_done) begin
               priority if (status.a_stop) begin
                  state_in = btfs_pkg::ST_FINISH;
               end else if (!status.div_exact) begin
                  cmd.a_next = 1'b1;
                  state_in   = btfs_pkg::ST_A_START;
               end else begin
                  cmd.rem_take = 1'b1;
                  cmd.b_init   = 1'b1;
                  state_in     = btfs_pkg::ST_B_START;
               end
            end
         end
         btfs_pkg::ST_B_START: begin
            cmd.div_start = 1'b1;
            cmd.div_sel_b = 1'b1;
            state_in      = btfs_pkg::ST_B_WAIT;
         end
         btfs_pkg::ST_B_WAIT: begin
            if (status.div_done) begin
               if (status.b_stop) begin
                  cmd.a_next = 1'b1;
                  state_in   = btfs_pkg::ST_A_START;
               end else begin
                  cmd.cand_take = status.div_exact;
                  cmd.b_next    = 1'b1;
                  state_in      = btfs_pkg::ST_B_START;
               end
            end
         end
         btfs_pkg::ST_FINISH: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = btfs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = btfs_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: hw/rtl/balanced_three_factor_split_top.sv
// Trials: one per outer factor a up to the cube root, plus one per inner factor b up to
// sqrt(count / a) for each a that divides the count; at 16 bits this stays under 2,500.
// One item at a time: a new count is taken only once the last result has moved to the
// output register. Reset: synchronous, active high; clears the controller, divider and
// output valid.
// ----------------------------------------------------------------------------
// Balanced three factor split: top level
// Splits a count into the three factors with the smallest spread.
// ----------------------------------------------------------------------------
`default_nettype none

// The search visits each factor triple once, as a <= b <= c, with a rising
// from one while a^3 does not exceed the count and, for each a dividing the
// count, b rising from a while b^2 does not exceed count / a. Every multiset
// of factors is therefore met first in its sorted form and in the same order
// as in an exhaustive scan, so ties still go to the earliest triple.
//
// A single restoring divider, one quotient bit per cycle, serves both
// loops. Its quotient also decides loop exit: the outer loop stops when
// a^2 exceeds count / a (kept as a running square, no multiplier) and the
// inner loop stops when count / (a * b) falls below b.
//
// A count of zero finds no triple and returns (1, 1, 0). The result sits in
// an output register, so a new item can be taken while the last result
// still waits for the consumer.

module balanced_three_factor_split_top (
   input  logic       clock,
   input  logic       reset,
   btfs_req_if.sink   req_ch,
   btfs_rsp_if.source rsp_ch
);

   btfs_pkg::cmd_type    cmd;
   btfs_pkg::status_type status;
   logic                 ready;

   // Sequencer for the two nested loops.
   btfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .status    (status),
      .req_ready (ready),
      .cmd       (cmd)
   );

   // Divider, loop registers, best triple and the output register.
   btfs_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .count      (req_ch.count),
      .cmd        (cmd),
      .status     (status),
      .rsp_ready  (rsp_ch.ready),
      .rsp_valid  (rsp_ch.valid),
      .rsp_large  (rsp_ch.factor_large),
      .rsp_middle (rsp_ch.factor_middle),
      .rsp_small  (rsp_ch.factor_small)
   );

   assign req_ch.ready = ready;

endmodule

`default_nettype wire

FILE: hw/rtl/btfs_checker.sv
// ----------------------------------------------------------------------------
// Balanced three factor split: port checker
// Concurrent checks on the top-level ports, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "balanced_three_factor_split_top_defines.svh"

module btfs_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input btfs_pkg::field_type rsp_large,
   input btfs_pkg::field_type rsp_middle,
   input btfs_pkg::field_type rsp_small
);

   // A result held back by the consumer keeps its value.
   `BTFS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_large) && $stable(rsp_middle) && $stable(rsp_small), "result changed while stalled")

   // Only one item is in the search at a time.
   `BTFS_ASSERT_NEXT(a_one_item, clock, reset, req_valid && req_ready, !req_ready, "second item taken during a search")

   // A fresh result only appears at the end of a search.
   `BTFS_ASSERT_IMPLIES(a_rsp_after_search, clock, reset, $rose(rsp_valid), $past(!req_ready), "result appeared without a search")

   // Reset leaves no result pending.
   `BTFS_ASSERT_IMPLIES(a_reset_clears, clock, 1'b0, $past(reset), !rsp_valid, "result pending after reset")

endmodule

bind balanced_three_factor_split_top btfs_checker u_btfs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_large  (rsp_ch.factor_large),
   .rsp_middle (rsp_ch.factor_middle),
   .rsp_small  (rsp_ch.factor_small)
);

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Balanced three factor split: testbench
// Sends counts into the block and checks every returned factor triple
// against a behavioral search that runs beside it. Both handshakes stall
// at random, and the consumer holds off for one long stretch.
// ----------------------------------------------------------------------------

module testbench;

   // A factor triple, largest member first.
   typedef struct packed {
      btfs_pkg::field_type biggest;
      btfs_pkg::field_type middle;
      btfs_pkg::field_type least;
   } factor_triple_type;

   // The limit sits far above the search for any one count, so the
   // watchdog only fires on a real hang.
   localparam int unsigned WATCHDOG_LIMIT = 3000000;
   // The consumer stops taking results for this long once.
   localparam int unsigned LONG_HOLD      = 4000;
   // Results already taken before the long hold starts.
   localparam int unsigned HOLD_AFTER     = 30;
   localparam int unsigned RANDOM_ITEMS   = 75;
   localparam int unsigned DRAIN_CYCLES   = 100;

   logic clock = 1'b0;
   logic reset;

   btfs_req_if req_ch ();
   btfs_rsp_if rsp_ch ();

   balanced_three_factor_split_top DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Counts still to be offered, and triples still owed by the block.
   btfs_pkg::field_type pending_counts[$];
   factor_triple_type   expected_triples[$];

   int unsigned fail_count   = 0;
   int unsigned results_seen = 0;
   int unsigned idle_cycles  = 0;

   // Handshakes seen at the last rising edge, used by the falling-edge drivers.
   logic req_taken = 1'b0;
   logic rsp_taken = 1'b0;

   // Orders three values, largest first.
   function automatic factor_triple_type order_desc(input int unsigned x,
                                                    input int unsigned y,
                                                    input int unsigned z);
      int unsigned t;
      factor_triple_type r;
      if (x < y) begin t = x; x = y; y = t; end
      if (y < z) begin t = y; y = z; z = t; end
      if (x < y) begin t = x; x = y; y = t; end
      r.biggest = btfs_pkg::field_type'(x);
      r.middle  = btfs_pkg::field_type'(y);
      r.least   = btfs_pkg::field_type'(z);
      return r;
   endfunction

   // Exhaustive divisor search: a rises while a^3 fits in the count, b rises
   // from a up to count / a, and only a strictly smaller spread replaces the
   // current best, so the first triple found wins a tie.
   function automatic factor_triple_type balanced_split(input btfs_pkg::field_type count);
      int unsigned n;
      int unsigned rest;
      int unsigned spread;
      int unsigned best_spread;
      bit found;
      factor_triple_type cand;
      factor_triple_type best;
      n = 32'(count);
      found = 1'b0;
      best_spread = 0;
      best = order_desc(1, 1, n);
      for (int unsigned a = 1; a <= n; a++) begin
         if (longint'(a) * a * a > longint'(n)) break;
         if (n % a != 0) continue;
         rest = n / a;
         for (int unsigned b = a; b <= rest; b++) begin
            if (rest % b != 0) continue;
            cand = order_desc(a, b, rest / b);
            spread = 32'(cand.biggest) - 32'(cand.least);
            if (!found || spread < best_spread) begin
               found = 1'b1;
               best_spread = spread;
               best = cand;
            end
         end
      end
      return best;
   endfunction

   // Mostly no gap, often a short one, seldom a long one.
   function automatic int unsigned draw_gap();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 50) return 0;
      else if (pick < 85) return $urandom_range(3, 1);
      else if (pick < 97) return $urandom_range(20, 4);
      else return $urandom_range(300, 40);
   endfunction

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("mismatch on result %0d: %s, got %0d, expected %0d",
               results_seen, what, got, want);
      fail_count++;
   endtask

   // ------------------------------------------------------------------------
   // Request driver. It offers the next pending count at a falling edge and
   // holds it until the handshake is seen; after each item it may idle for a
   // random number of cycles. Now and then it runs a burst with no gaps.
   // ------------------------------------------------------------------------
   int unsigned drv_gap_left = 0;
   int unsigned drv_calm     = 0;

   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.count <= '0;
         drv_gap_left = 0;
      end else if (req_ch.valid && !req_taken) begin
         // The current item has not been taken yet, so it stays on the bus.
      end else if (drv_gap_left > 0) begin
         req_ch.valid <= 1'b0;
         drv_gap_left = drv_gap_left - 1;
      end else if (pending_counts.size() > 0) begin
         req_ch.valid <= 1'b1;
         req_ch.count <= pending_counts.pop_front();
         if (drv_calm > 0) begin
            drv_gap_left = 0;
            drv_calm = drv_calm - 1;
         end else begin
            drv_gap_left = draw_gap();
            if ($urandom_range(15) == 0) drv_calm = $urandom_range(15, 5);
         end
      end else begin
         req_ch.valid <= 1'b0;
      end
   end

   // ------------------------------------------------------------------------
   // Response ready. After each item taken the consumer may stall for a
   // random gap. Once enough results have come it holds ready low for a long
   // stretch, so the block fills its output register, takes one more count
   // and then has to stall its input while the driver keeps offering.
   // ------------------------------------------------------------------------
   int unsigned rsp_gap_left  = 0;
   int unsigned rsp_calm      = 0;
   int unsigned hold_left     = 0;
   bit          hold_done     = 1'b0;
   int unsigned rsp_gap       = 0;

   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left = hold_left - 1;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
         rsp_ch.ready <= 1'b0;
         hold_left = LONG_HOLD - 1;
         hold_done = 1'b1;
      end else if (rsp_taken) begin
         if (rsp_calm > 0) begin
            rsp_gap = 0;
            rsp_calm = rsp_calm - 1;
         end else begin
            rsp_gap = draw_gap();
            if ($urandom_range(15) == 0) rsp_calm = $urandom_range(15, 5);
         end
         if (rsp_gap > 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_gap_left = rsp_gap - 1;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end else if (rsp_gap_left > 0) begin
         rsp_ch.ready <= 1'b0;
         rsp_gap_left = rsp_gap_left - 1;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------------
   // Monitor. At each rising edge an accepted count gets its predicted
   // triple queued, and an accepted result is checked field by field
   // against the oldest prediction.
   // ------------------------------------------------------------------------
   factor_triple_type want;

   always @(posedge clock) begin
      req_taken <= req_ch.valid && req_ch.ready;
      rsp_taken <= rsp_ch.valid && rsp_ch.ready;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            expected_triples.push_back(balanced_split(req_ch.count));
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_triples.size() == 0) begin
               report_mismatch("result with nothing expected",
                               32'(rsp_ch.factor_large), 0);
            end else begin
               want = expected_triples.pop_front();
               if (rsp_ch.factor_large !== want.biggest)
                  report_mismatch("factor_large", 32'(rsp_ch.factor_large),
                                  32'(want.biggest));
               if (rsp_ch.factor_middle !== want.middle)
                  report_mismatch("factor_middle", 32'(rsp_ch.factor_middle),
                                  32'(want.middle));
               if (rsp_ch.factor_small !== want.least)
                  report_mismatch("factor_small", 32'(rsp_ch.factor_small),
                                  32'(want.least));
            end
            results_seen++;
         end
      end
   end

   // Watchdog: ends the run when no item moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired after %0d idle cycles", idle_cycles);
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus and end of run.
   // ------------------------------------------------------------------------
   int unsigned pick;

   initial begin
      req_ch.valid = 1'b0;
      req_ch.count = '0;
      rsp_ch.ready = 1'b0;
      reset = 1'b1;

      // Directed counts: zero, one, small primes and cubes, ties, powers of
      // two, alternating bit patterns and the top of the range.
      pending_counts.push_back(16'd0);
      pending_counts.push_back(16'd1);
      pending_counts.push_back(16'd2);
      pending_counts.push_back(16'd3);
      pending_counts.push_back(16'd4);
      pending_counts.push_back(16'd7);
      pending_counts.push_back(16'd8);
      pending_counts.push_back(16'd12);
      pending_counts.push_back(16'd27);
      pending_counts.push_back(16'd64);
      pending_counts.push_back(16'd97);
      pending_counts.push_back(16'd100);
      pending_counts.push_back(16'd210);
      pending_counts.push_back(16'd360);
      pending_counts.push_back(16'd1000);
      pending_counts.push_back(16'd1024);
      pending_counts.push_back(16'd4096);
      pending_counts.push_back(16'd4913);
      pending_counts.push_back(16'h5555);
      pending_counts.push_back(16'hAAAA);
      pending_counts.push_back(16'h8000);
      pending_counts.push_back(16'd65521);
      pending_counts.push_back(16'hFFFE);
      pending_counts.push_back(16'hFFFF);
      pending_counts.push_back(16'd60060);

      // Random counts. Large counts take long searches, so most are small;
      // products of small factors give cubes and ties in the spread.
      for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
         pick = $urandom_range(99);
         if (pick < 60)
            pending_counts.push_back(btfs_pkg::field_type'($urandom_range(255)));
         else if (pick < 75)
            pending_counts.push_back(btfs_pkg::field_type'($urandom_range(12, 1) *
                                                           $urandom_range(12, 1) *
                                                           $urandom_range(12, 1)));
         else if (pick < 92)
            pending_counts.push_back(btfs_pkg::field_type'($urandom_range(4095)));
         else
            pending_counts.push_back(btfs_pkg::field_type'($urandom_range(65535)));
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Wait until every count has gone in and every triple has come back.
      do @(posedge clock);
      while (pending_counts.size() != 0 || req_ch.valid || expected_triples.size() != 0);

      // A short drain catches any result that should not be there.
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

FILE: balanced_three_factor_split_top.f
+incdir+hw/rtl
hw/rtl/btfs_pkg.sv
hw/rtl/btfs_req_if.sv
hw/rtl/btfs_rsp_if.sv
hw/rtl/btfs_divider.sv
hw/rtl/btfs_datapath.sv
hw/rtl/btfs_ctrl.sv
hw/rtl/balanced_three_factor_split_top.sv
hw/rtl/btfs_checker.sv
tb/testbench.sv
